/* rtl/core/assert_macros.svh */
// assertion macros used by thermistor_table_interpolator.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tti_pkg.sv */
// types and constants for the thermistor table interpolator
// no dependencies
`default_nettype none

package tti_pkg;

  localparam int CODE_W     = 16;
  localparam int TEMP_W     = 16;
  localparam int MEM_W      = CODE_W + TEMP_W;
  localparam int PTS_W      = 9;
  localparam int IDX_W      = 8;
  localparam int Q8_W       = 24;
  localparam int FRAC_W     = 8;
  localparam int PROD_W     = 2 * CODE_W;
  localparam int DIVD_W     = PROD_W + FRAC_W;
  localparam int REM_W      = CODE_W + 1;
  localparam int BASE_W     = DIVD_W + 2;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STEPS  = DIVD_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int Q8_MAX     = 8388607;
  localparam int Q8_MIN     = -8388608;

  localparam logic [PTS_W-1:0] PTS_RESET = 9'd256;

  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  typedef struct packed {
    logic                     req_type;
    logic [IDX_W-1:0]         entry_index;
    logic [CODE_W-1:0]        entry_code;
    logic signed [TEMP_W-1:0] entry_temperature;
    logic [CODE_W-1:0]        sample_code;
  } tti_in_t;

  typedef struct packed {
    logic signed [Q8_W-1:0] temperature_q8;
    logic                   saturated;
  } tti_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_FETCH_LO,
    ST_FETCH_HI,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } tti_state_t;

endpackage

`default_nettype wire

/* rtl/core/thermistor_table_interpolator.sv */
// ntc thermistor table lookup with bisection search and linear interpolation
// depends on tti_pkg and assert_macros.svh
//
//   channel | ports                            | moves
//   in      | in_valid in_ready in_data        | table write or convert item
//   out     | out_valid out_ready out_data     | q8 temperature and clip flag
//   cfg     | cfg_valid cfg_ready cfg_data     | points_in_use
//
// a write item is stored straight from idle and leaves the block idle; a convert item
// bisects on the single read port, a read state and a compare state per step, then runs
// the 2-bit-per-cycle divider, which equal pair codes skip
// the finished result sits in an output register, so a stalled out side holds
// only the next convert item at its last step
// reset is synchronous; the table is not cleared and needs no clearing pass
`default_nettype none
`include "assert_macros.svh"

module thermistor_table_interpolator
  import tti_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire tti_in_t          in_data,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      tti_out_t         out_data,
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [PTS_W-1:0] cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int WW = (CW > PTS_W) ? CW : PTS_W;

  tti_state_t state_r, state_nxt;

  logic [PTS_W-1:0]         points_r;
  logic [MEM_W-1:0]         tbl_mem [TABLE_DEPTH];
  logic [MEM_W-1:0]         rd_data_r;
  logic [AW-1:0]            rd_addr;
  logic                     tbl_we;
  logic                     in_acc;

  logic [WW-1:0]            pts_ext, n_eff, idx_ext;
  logic [AW-1:0]            last_init, mid_init;
  logic                     wr_ok;

  logic [AW-1:0]            first_r, last_r, mid_r;
  logic [AW-1:0]            first_nxt, last_nxt, mid_nxt;
  logic [AW:0]              mid_sum;
  logic                     srch_more;
  logic [CODE_W-1:0]        sample_r;

  logic [CODE_W-1:0]        ca_r, cb, clo, d_w, dc_w;
  logic signed [TEMP_W-1:0] ta_r, tb, tlo_w;
  logic signed [TEMP_W:0]   tdiff;
  logic [TEMP_W-1:0]        dt_w;

  logic signed [TEMP_W-1:0] tlo_r;
  logic [CODE_W-1:0]        d_r, dt_r, dc_r;

  logic [PROD_W-1:0]        prod;
  logic [DIVD_W-1:0]        quo_r, quo_w;
  logic [CODE_W-1:0]        rem_r, rem_w;
  logic [REM_W-1:0]         rem_ext;
  logic [DIV_CNT_W-1:0]     div_cnt_r;
  logic                     div_last;

  logic signed [BASE_W-1:0] base_sum, base_r, fin;
  logic                     round_up_r;

  logic                     out_free, out_load;
  logic                     out_valid_r;
  tti_out_t                 out_data_r, res_w;

  // effective point count and search start
  always_comb begin
    pts_ext = WW'(points_r);
    if (pts_ext < WW'(2)) begin
      n_eff = WW'(2);
    end else if (pts_ext > WW'(TABLE_DEPTH)) begin
      n_eff = WW'(TABLE_DEPTH);
    end else begin
      n_eff = pts_ext;
    end
    last_init = AW'(n_eff - WW'(1));
    mid_init  = AW'(n_eff >> 1);
    idx_ext   = WW'(in_data.entry_index);
    wr_ok     = idx_ext < WW'(TABLE_DEPTH);
  end

  // bisection step
  always_comb begin
    if (rd_data_r[MEM_W-1 -: CODE_W] < sample_r) begin
      first_nxt = first_r;
      last_nxt  = mid_r;
    end else begin
      first_nxt = mid_r;
      last_nxt  = last_r;
    end
    mid_sum   = {1'b0, first_nxt} + {1'b0, last_nxt};
    mid_nxt   = mid_sum[AW:1];
    srch_more = (last_nxt - first_nxt) > AW'(1);
  end

  // pair differences
  always_comb begin
    cb    = rd_data_r[MEM_W-1 -: CODE_W];
    tb    = rd_data_r[TEMP_W-1:0];
    tlo_w = (ta_r < tb) ? ta_r : tb;
    clo   = (ca_r < cb) ? ca_r : cb;
    d_w   = (sample_r > clo) ? (sample_r - clo) : (clo - sample_r);
    dc_w  = (ca_r > cb) ? (ca_r - cb) : (cb - ca_r);
    tdiff = {ta_r[TEMP_W-1], ta_r} - {tb[TEMP_W-1], tb};
    dt_w  = tdiff[TEMP_W] ? TEMP_W'(-tdiff) : tdiff[TEMP_W-1:0];
  end

  // restoring divider, two quotient bits per cycle
  always_comb begin
    rem_w   = rem_r;
    quo_w   = quo_r;
    rem_ext = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_ext = {rem_w, quo_w[DIVD_W-1]};
      quo_w   = {quo_w[DIVD_W-2:0], 1'b0};
      if (rem_ext >= {1'b0, dc_r}) begin
        rem_w    = CODE_W'(rem_ext - {1'b0, dc_r});
        quo_w[0] = 1'b1;
      end else begin
        rem_w = rem_ext[CODE_W-1:0];
      end
    end
    div_last = div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1);
  end

  // base value, final rounding and clipping
  always_comb begin
    prod     = d_r * dt_r;
    base_sum = $signed({{(BASE_W-TEMP_W-FRAC_W){tlo_r[TEMP_W-1]}}, tlo_r, FRAC_W'(0)})
             + $signed({(BASE_W-DIVD_W)'(0), quo_r});
    fin      = base_r + $signed(BASE_W'(round_up_r));
    if (fin > BASE_W'(Q8_MAX)) begin
      res_w.temperature_q8 = Q8_W'(Q8_MAX);
      res_w.saturated      = 1'b1;
    end else if (fin < BASE_W'(Q8_MIN)) begin
      res_w.temperature_q8 = Q8_W'(Q8_MIN);
      res_w.saturated      = 1'b1;
    end else begin
      res_w.temperature_q8 = fin[Q8_W-1:0];
      res_w.saturated      = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.req_type == REQ_CONVERT) begin
          state_nxt = (last_init > AW'(1)) ? ST_SRCH_RD : ST_FETCH_LO;
        end
      end
      ST_SRCH_RD:  state_nxt = ST_SRCH_CMP;
      ST_SRCH_CMP: state_nxt = srch_more ? ST_SRCH_RD : ST_FETCH_LO;
      ST_FETCH_LO: state_nxt = ST_FETCH_HI;
      ST_FETCH_HI: state_nxt = ST_PREP;
      ST_PREP:     state_nxt = ST_MUL;
      ST_MUL:      state_nxt = (dc_r == '0) ? ST_FIX : ST_DIV;
      ST_DIV:      state_nxt = div_last ? ST_FIX : ST_DIV;
      ST_FIX:      state_nxt = ST_DONE;
      ST_DONE:     state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    rd_addr  = mid_r;
    unique case (state_r)
      ST_IDLE:     in_ready = 1'b1;
      ST_SRCH_RD:  rd_addr  = mid_r;
      ST_FETCH_LO: rd_addr  = first_r;
      ST_FETCH_HI: rd_addr  = last_r;
      default:     rd_addr  = mid_r;
    endcase
    in_acc    = in_valid && in_ready;
    tbl_we    = in_acc && in_data.req_type == REQ_WRITE && wr_ok;
    cfg_ready = 1'b1;
    out_free  = !out_valid_r || out_ready;
    out_load  = state_r == ST_DONE && out_free;
  end

  // table memory
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[idx_ext[AW-1:0]] <= {in_data.entry_code, in_data.entry_temperature};
    end
    rd_data_r <= tbl_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      points_r    <= PTS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        points_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          first_r  <= '0;
          last_r   <= last_init;
          mid_r    <= mid_init;
          sample_r <= in_data.sample_code;
        end
      end
      ST_SRCH_CMP: begin
        first_r <= first_nxt;
        last_r  <= last_nxt;
        mid_r   <= mid_nxt;
      end
      ST_FETCH_HI: begin
        ca_r <= rd_data_r[MEM_W-1 -: CODE_W];
        ta_r <= rd_data_r[TEMP_W-1:0];
      end
      ST_PREP: begin
        tlo_r <= tlo_w;
        d_r   <= d_w;
        dt_r  <= dt_w;
        dc_r  <= dc_w;
      end
      ST_MUL: begin
        quo_r     <= (dc_r == '0) ? '0 : {prod, FRAC_W'(0)};
        rem_r     <= '0;
        div_cnt_r <= '0;
      end
      ST_DIV: begin
        quo_r     <= quo_w;
        rem_r     <= rem_w;
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      ST_FIX: begin
        base_r     <= base_sum;
        round_up_r <= base_sum[BASE_W-1] && rem_r != '0;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_data_r <= res_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_SAME(a_mid_inside, clk, rst_n, state_r == ST_SRCH_RD, (mid_r > first_r) && (mid_r < last_r), "bisection midpoint outside its bracket")
  `ASSERT_SAME(a_span_open, clk, rst_n, state_r == ST_SRCH_CMP, (last_r - first_r) > AW'(1), "bisection step on a closed bracket")
  `ASSERT_SAME(a_rem_below, clk, rst_n, state_r == ST_DIV, rem_r < dc_r, "divider remainder not below divisor")
  `ASSERT_SAME(a_sat_limit, clk, rst_n, out_valid_r && out_data_r.saturated, (out_data_r.temperature_q8 == Q8_W'(Q8_MAX)) || (out_data_r.temperature_q8 == Q8_W'(Q8_MIN)), "clipped item not at a range limit")
  `ASSERT_NEXT(a_done_holds, clk, rst_n, state_r == ST_DONE && !out_free, state_r == ST_DONE, "finished item dropped under stall")

endmodule

`default_nettype wire

/* tb/tb_thermistor_table_interpolator.sv */
// self-checking testbench for thermistor_table_interpolator
// loads code/temperature tables, converts samples and checks each q8 result
// against a bisection and interpolation predictor; depends on tti_pkg and thermistor_table_interpolator
module tb_thermistor_table_interpolator;
  import tti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 256;
  localparam int TARGET_ITEMS = 1950;
  localparam int QUIET_ITEMS  = 250;
  localparam int SETTLE       = 48;
  localparam int STUCK_LIMIT  = 4000;

  class temperature_scoreboard;
    logic [CODE_W-1:0]        code_tab[DEPTH];
    logic signed [TEMP_W-1:0] temp_tab[DEPTH];
    logic [PTS_W-1:0]         points_in_use;
    tti_out_t                 expected_temps[$];
    int                       errors;

    function new();
      points_in_use = PTS_RESET;
      errors = 0;
    endfunction

    function void set_points(logic [PTS_W-1:0] v);
      points_in_use = v;
    endfunction

    function tti_out_t interpolate(logic [CODE_W-1:0] sample);
      int unsigned n, first, last, mid;
      longint s, ca, cb, ta, tb, tlo, clo, d, dt, dc, q;
      tti_out_t r;
      n = points_in_use;
      if (n < 2) n = 2;
      if (n > DEPTH) n = DEPTH;
      first = 0;
      last = n - 1;
      mid = n / 2;
      while (last - first > 1) begin
        if (code_tab[mid] < sample) last = mid;
        else first = mid;
        mid = (first + last) / 2;
      end
      s = sample;
      ca = code_tab[first];
      cb = code_tab[last];
      ta = temp_tab[first];
      tb = temp_tab[last];
      tlo = (ta < tb) ? ta : tb;
      clo = (ca < cb) ? ca : cb;
      d = (s > clo) ? s - clo : clo - s;
      dt = (ta > tb) ? ta - tb : tb - ta;
      dc = (ca > cb) ? ca - cb : cb - ca;
      if (dc == 0) q = tlo * 256;
      else q = (tlo * 256 * dc + d * dt * 256) / dc;
      r.saturated = 1'b0;
      if (q > Q8_MAX) begin
        q = Q8_MAX;
        r.saturated = 1'b1;
      end else if (q < Q8_MIN) begin
        q = Q8_MIN;
        r.saturated = 1'b1;
      end
      r.temperature_q8 = q[Q8_W-1:0];
      return r;
    endfunction

    function void note_item(tti_in_t it);
      if (it.req_type == REQ_WRITE) begin
        code_tab[it.entry_index] = it.entry_code;
        temp_tab[it.entry_index] = it.entry_temperature;
      end else begin
        expected_temps.push_back(interpolate(it.sample_code));
      end
    endfunction

    function void check_temperature(tti_out_t got);
      tti_out_t want;
      if (expected_temps.size() == 0) begin
        $display("%0t: unexpected item, expected none got temperature_q8 %0d saturated %0d",
                 $time, got.temperature_q8, got.saturated);
        errors++;
        return;
      end
      want = expected_temps.pop_front();
      if (got.temperature_q8 !== want.temperature_q8) begin
        $display("%0t: temperature_q8 expected %0d got %0d",
                 $time, want.temperature_q8, got.temperature_q8);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %0d got %0d", $time, want.saturated, got.saturated);
        errors++;
      end
    endfunction

    function int pending();
      return expected_temps.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  tti_in_t          in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  tti_out_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [PTS_W-1:0] cfg_data = '0;

  temperature_scoreboard sb = new();
  logic [CODE_W-1:0] loaded_codes[DEPTH];
  int  items_sent = 0;
  bit  gaps_on = 1'b0;
  bit  rx_stall_on = 1'b0;
  int  rx_hold = 0;
  int  stuck_cycles = 0;

  thermistor_table_interpolator #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_data);
      if (out_valid && out_ready) sb.check_temperature(out_data);
      if (cfg_valid && cfg_ready) sb.set_points(cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
      rx_hold <= $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_item(input tti_in_t it);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    if (it.req_type == REQ_WRITE) loaded_codes[it.entry_index] = it.entry_code;
    items_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_write(input int idx, input logic [CODE_W-1:0] code,
                            input logic signed [TEMP_W-1:0] temp);
    tti_in_t it;
    logic [63:0] r;
    r = {$urandom, $urandom};
    it = r[$bits(tti_in_t)-1:0];
    it.req_type = REQ_WRITE;
    it.entry_index = idx[IDX_W-1:0];
    it.entry_code = code;
    it.entry_temperature = temp;
    send_item(it);
  endtask

  task automatic send_convert(input logic [CODE_W-1:0] sample);
    tti_in_t it;
    logic [63:0] r;
    r = {$urandom, $urandom};
    it = r[$bits(tti_in_t)-1:0];
    it.req_type = REQ_CONVERT;
    it.sample_code = sample;
    send_item(it);
  endtask

  // lower valid, let every result come back, then give trailing writes time to land
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_points(input logic [PTS_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // falling codes over entries 0..n-1, with some repeated codes
  task automatic load_falling(input int n);
    int unsigned vals[$];
    int t;
    bit smooth;
    smooth = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 7) == 0) vals.push_back(vals[i-1]);
      else vals.push_back($urandom_range(0, 65535));
    end
    vals.rsort();
    t = $urandom_range(0, 65535) - 32768;
    for (int i = 0; i < n; i++) begin
      if (smooth) begin
        t = t + $urandom_range(0, 400);
        if (t > 32767) t = 32767;
      end else begin
        t = $urandom_range(0, 65535) - 32768;
      end
      send_write(i, vals[i][CODE_W-1:0], t[TEMP_W-1:0]);
    end
  endtask

  initial begin
    int pts, n, batch;
    logic [CODE_W-1:0] lo, hi;
    bit quiet;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two-point table: extremes, equal codes, clipping
    write_points(9'd2);
    gaps_on = 1'b1;
    rx_stall_on = 1'b1;
    send_write(0, 16'hffff, 16'sh7fff);
    send_write(1, 16'h0000, 16'sh8000);
    send_convert(16'h0000);
    send_convert(16'hffff);
    send_convert(16'h8000);
    send_write(1, 16'hffff, 16'sd100);
    send_convert(16'h1234);
    send_write(0, 16'd100, 16'sh8000);
    send_write(1, 16'd50, 16'sh7fff);
    send_convert(16'hffff);
    send_convert(16'd75);
    send_convert(16'h0000);
    send_write(255, 16'h5555, 16'sh0000);
    send_write(128, 16'haaaa, 16'sh00ff);
    wait_for_results();
    write_points(9'd0);
    send_convert(16'd60);
    send_convert(16'd99);
    wait_for_results();
    write_points(9'd1);
    send_convert(16'd101);
    wait_for_results();

    load_falling(DEPTH);
    wait_for_results();
    write_points(9'd511);
    send_convert(16'h0000);
    send_convert(16'hffff);
    send_convert(loaded_codes[128]);

    while (items_sent < TARGET_ITEMS) begin
      wait_for_results();
      quiet = items_sent > TARGET_ITEMS - QUIET_ITEMS;
      gaps_on = !quiet && $urandom_range(0, 2) != 0;
      rx_stall_on = !quiet && $urandom_range(0, 2) != 0;
      case ($urandom_range(0, 9))
        0: pts = $urandom_range(0, 1);
        1: pts = 2;
        2: pts = 256;
        3: pts = $urandom_range(257, 511);
        4: pts = $urandom_range(2, 16);
        default: pts = $urandom_range(2, $urandom_range(0, 1) ? 32 : 256);
      endcase
      write_points(pts[PTS_W-1:0]);
      n = (pts < 2) ? 2 : (pts > DEPTH) ? DEPTH : pts;
      if ($urandom_range(0, 2) == 0) load_falling(n);
      batch = $urandom_range(15, 60);
      repeat (batch) begin
        if ($urandom_range(0, 11) == 0) begin
          send_write($urandom_range(0, DEPTH - 1), CODE_W'($urandom_range(0, 65535)),
                     TEMP_W'($urandom_range(0, 65535)));
        end else begin
          lo = loaded_codes[n-1];
          hi = loaded_codes[0];
          case ($urandom_range(0, 9))
            0: send_convert($urandom_range(0, 1) ? 16'hffff : 16'h0000);
            1: send_convert(CODE_W'($urandom_range(0, 65535)));
            2: send_convert(loaded_codes[$urandom_range(0, n - 1)]);
            default: send_convert(CODE_W'($urandom_range(lo, hi)));
          endcase
        end
      end
    end

    wait_for_results();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
